// ===== hdl/sbpd_pkg.sv =====
// ----------------------------------------------------------------------------
// sbpd_pkg
// Shared types, codes and helper functions of the signer bitmap pair decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package sbpd_pkg;

  // Largest bit count a header may declare.
  localparam logic [15:0] MAX_SET_BITS = 16'd2048;

  // Result queue depth and its derived widths.
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = PTR_W + 1;

  // Positions per payload byte in each format.
  localparam logic [3:0] BITS_PER_BYTE  = 4'd8;
  localparam logic [3:0] TRITS_PER_BYTE = 4'd5;

  // Header versions.
  localparam logic [7:0] VER_BINARY = 8'd0;
  localparam logic [7:0] VER_PAIR   = 8'd1;

  // Result kinds.
  localparam logic KIND_CHUNK  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_SIZE   = 2'd1;
  localparam logic [1:0] ST_FORMAT = 2'd2;

  // Header walk: three header bytes, then payload.
  typedef enum logic [1:0] {
    HS_VERSION,
    HS_LEN_LO,
    HS_LEN_HI,
    HS_PAYLOAD
  } hdr_state_t;

  // One result item.
  typedef struct packed {
    logic        item_kind;
    logic [15:0] first_index;
    logic [7:0]  set_a_bits;
    logic [4:0]  set_b_bits;
    logic [3:0]  valid_count;
    logic [1:0]  status;
    logic        format_seen;
    logic [15:0] total_bits;
    logic        final_item;
  } res_t;

  // Up to two results from one request; the second is only used with the first.
  typedef struct packed {
    logic v0;
    res_t item0;
    logic v1;
    res_t item1;
  } push_t;

  // Set A / set B masks of the five low base-3 digits of a byte.
  typedef struct packed {
    logic [4:0] a;
    logic [4:0] b;
  } trit_t;

  // Split a byte into five base-3 digits, least significant first.
  // Division by three is a multiply by 171 and a shift by 9 (exact below 512).
  function automatic trit_t trit_split(input logic [7:0] v);
    trit_t       t;
    logic [7:0]  rem;
    logic [15:0] prod;
    logic [7:0]  q;
    logic [7:0]  d8;
    t   = '0;
    rem = v;
    for (int j = 0; j < 5; j++) begin
      prod = {8'd0, rem} * 16'd171;
      q    = {1'b0, prod[15:9]};
      d8   = rem - (q + {q[6:0], 1'b0});
      t.a[j] = (d8[1:0] == 2'd1);
      t.b[j] = (d8[1:0] == 2'd2);
      rem  = q;
    end
    return t;
  endfunction

  // Mask of the low cnt bits, cnt from 0 to 8.
  function automatic logic [7:0] low_mask(input logic [3:0] cnt);
    logic [8:0] m;
    m = (9'd1 << cnt) - 9'd1;
    return m[7:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/sbpd_decode.sv =====
// ----------------------------------------------------------------------------
// sbpd_decode
// Message state and the per-byte decode into chunk and status results.
// ----------------------------------------------------------------------------
`default_nettype none

module sbpd_decode (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          take,
  input  wire logic [7:0]    data_byte,
  input  wire logic          end_of_message,
  input  wire logic          pair_mode,
  output sbpd_pkg::push_t    push
);

  sbpd_pkg::hdr_state_t hs_r, hs_nxt;
  logic [7:0]  version_r, version_nxt;
  logic [15:0] declared_r, declared_nxt;
  logic [1:0]  early_r, early_nxt;
  logic [16:0] start_r, start_nxt;   // bit index of the next chunk
  logic        beyond_r, beyond_nxt; // a byte came past the expected count

  logic              is_pair;
  logic [3:0]        per;
  logic              below;
  logic [15:0]       left;
  logic [3:0]        cnt;
  logic [15:0]       decl_full;
  sbpd_pkg::trit_t   trits;
  logic [7:0]        mask;
  logic              chunk_v;
  logic              stat_v;
  logic              short_hdr;
  sbpd_pkg::res_t    chunk;
  sbpd_pkg::res_t    stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hs_r       <= sbpd_pkg::HS_VERSION;
      version_r  <= '0;
      declared_r <= '0;
      early_r    <= sbpd_pkg::ST_OK;
      start_r    <= '0;
      beyond_r   <= 1'b0;
    end else if (take) begin
      hs_r       <= hs_nxt;
      version_r  <= version_nxt;
      declared_r <= declared_nxt;
      early_r    <= early_nxt;
      start_r    <= start_nxt;
      beyond_r   <= beyond_nxt;
    end
  end

  always_comb begin
    hs_nxt       = hs_r;
    version_nxt  = version_r;
    declared_nxt = declared_r;
    early_nxt    = early_r;
    start_nxt    = start_r;
    beyond_nxt   = beyond_r;
    chunk_v      = 1'b0;
    short_hdr    = 1'b0;

    is_pair   = (version_r == sbpd_pkg::VER_PAIR);
    per       = is_pair ? sbpd_pkg::TRITS_PER_BYTE : sbpd_pkg::BITS_PER_BYTE;
    below     = ({1'b0, declared_r} > start_r);
    left      = declared_r - start_r[15:0];
    cnt       = (left < {12'd0, per}) ? left[3:0] : per;
    trits     = sbpd_pkg::trit_split(data_byte);
    mask      = sbpd_pkg::low_mask(cnt);
    decl_full = {data_byte, declared_r[7:0]};

    case (hs_r)
      sbpd_pkg::HS_VERSION: begin
        version_nxt = data_byte;
        hs_nxt      = sbpd_pkg::HS_LEN_LO;
        short_hdr   = end_of_message;
      end
      sbpd_pkg::HS_LEN_LO: begin
        declared_nxt = {8'd0, data_byte};
        hs_nxt       = sbpd_pkg::HS_LEN_HI;
        short_hdr    = end_of_message;
      end
      sbpd_pkg::HS_LEN_HI: begin
        declared_nxt = decl_full;
        hs_nxt       = sbpd_pkg::HS_PAYLOAD;
        // Format check ranks above the size check.
        if (version_r > {7'd0, pair_mode}) begin
          early_nxt = sbpd_pkg::ST_FORMAT;
        end else if (decl_full > sbpd_pkg::MAX_SET_BITS) begin
          early_nxt = sbpd_pkg::ST_SIZE;
        end else begin
          early_nxt = sbpd_pkg::ST_OK;
        end
      end
      sbpd_pkg::HS_PAYLOAD: begin
        chunk_v = (early_r == sbpd_pkg::ST_OK) && below;
        if (chunk_v) begin
          start_nxt = start_r + {13'd0, per};
        end else if (!below) begin
          beyond_nxt = 1'b1;
        end
      end
      default: begin
        hs_nxt = sbpd_pkg::HS_VERSION;
      end
    endcase

    chunk             = '0;
    chunk.item_kind   = sbpd_pkg::KIND_CHUNK;
    chunk.first_index = start_r[15:0];
    chunk.set_a_bits  = is_pair ? ({3'd0, trits.a} & mask) : (data_byte & mask);
    chunk.set_b_bits  = is_pair ? (trits.b & mask[4:0]) : 5'd0;
    chunk.valid_count = cnt;
    chunk.status      = sbpd_pkg::ST_OK;
    chunk.format_seen = is_pair;
    chunk.total_bits  = declared_r;
    chunk.final_item  = 1'b0;

    stat            = '0;
    stat.item_kind  = sbpd_pkg::KIND_STATUS;
    stat.final_item = 1'b1;
    if (short_hdr) begin
      stat.status = sbpd_pkg::ST_SIZE;
    end else begin
      if (early_nxt != sbpd_pkg::ST_OK) begin
        stat.status = early_nxt;
      end else if ((start_nxt >= {1'b0, declared_nxt}) && !beyond_nxt) begin
        stat.status = sbpd_pkg::ST_OK;
      end else begin
        stat.status = sbpd_pkg::ST_FORMAT;
      end
      stat.format_seen = (version_nxt == sbpd_pkg::VER_PAIR);
      stat.total_bits  = declared_nxt;
    end
    stat_v = end_of_message;

    // Drop all message state once the status goes out.
    if (end_of_message) begin
      hs_nxt       = sbpd_pkg::HS_VERSION;
      version_nxt  = '0;
      declared_nxt = '0;
      early_nxt    = sbpd_pkg::ST_OK;
      start_nxt    = '0;
      beyond_nxt   = 1'b0;
    end

    push.v0    = take && (chunk_v || stat_v);
    push.item0 = chunk_v ? chunk : stat;
    push.v1    = take && chunk_v && stat_v;
    push.item1 = stat;
  end

`ifndef ASSERT_OFF
  a_chunk_in_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (take && chunk_v) |-> (hs_r == sbpd_pkg::HS_PAYLOAD))
    else $error("chunk decoded outside the payload");

  a_status_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (take && end_of_message) |=> (hs_r == sbpd_pkg::HS_VERSION && start_r == '0))
    else $error("message state not cleared after status");
`endif

endmodule

`default_nettype wire

// ===== hdl/sbpd_out_fifo.sv =====
// ----------------------------------------------------------------------------
// sbpd_out_fifo
// Small result queue: takes one or two results per cycle, gives one.
// ----------------------------------------------------------------------------
`default_nettype none

module sbpd_out_fifo (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire sbpd_pkg::push_t push,
  output logic             room,
  output logic             out_valid,
  input  wire logic        out_ready,
  output sbpd_pkg::res_t   out_item
);

  sbpd_pkg::res_t mem_r [sbpd_pkg::FIFO_DEPTH];
  logic [sbpd_pkg::PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [sbpd_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [sbpd_pkg::PTR_W-1:0] wr_ptr_nxt, rd_ptr_nxt;
  logic                       pop;

  assign out_valid = (cnt_r != '0);
  assign out_item  = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  // Two free slots are needed for a request that yields two results.
  assign room      = (cnt_r <= sbpd_pkg::CNT_W'(sbpd_pkg::FIFO_DEPTH - 2));

  always_comb begin
    cnt_nxt    = cnt_r + sbpd_pkg::CNT_W'(push.v0) + sbpd_pkg::CNT_W'(push.v1)
                 - sbpd_pkg::CNT_W'(pop);
    wr_ptr_nxt = wr_ptr_r + sbpd_pkg::PTR_W'(push.v0) + sbpd_pkg::PTR_W'(push.v1);
    rd_ptr_nxt = rd_ptr_r + sbpd_pkg::PTR_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.v0) begin
      mem_r[wr_ptr_r] <= push.item0;
    end
    if (push.v1) begin
      mem_r[wr_ptr_r + sbpd_pkg::PTR_W'(1)] <= push.item1;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.v0 |-> room)
    else $error("result pushed without two free slots");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    push.v1 |-> push.v0)
    else $error("second result without a first");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push.v0) |=> (cnt_r == $past(cnt_r) - sbpd_pkg::CNT_W'(1)))
    else $error("fill count wrong after a lone read");
`endif

endmodule

`default_nettype wire

// ===== hdl/signer_bitmap_pair_decoder.sv =====
// ----------------------------------------------------------------------------
// signer_bitmap_pair_decoder
// Byte-stream decoder for a serialized signer bitmap (binary or base-3 pair).
// ----------------------------------------------------------------------------
// The block takes one message byte per request and sustains one request per
// clock while the result queue has room for two results. A message starts
// with three header bytes (version, then a 16-bit bit count, low byte first).
// Each payload byte within the expected count of a message whose header
// passed its checks yields one chunk result; the byte flagged with in_tlast
// also yields a status result with out_tlast high. That final byte, when it
// also carries a chunk, yields two results, which leave one at a time through
// the result queue; with out_tready held high this is the only case that can
// stall input, otherwise receiver stalls back up into in_tready once the
// queue fills. A request waits in the input register and passes through the
// decode into the result queue, whose head drives out_tvalid and the result.
// Chunks are sent before the status is known, so a
// consumer must drop a message's chunks when its status is not success.
// cfg_data sets pair mode (reset 1: versions 0 and 1 accepted; 0: version 0
// only); write it only while no message is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module signer_bitmap_pair_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,

  // Input bytes.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tlast,   // end_of_message

  // Results.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // [15:0] first_index, [23:16] set_a_bits,
                                       // [28:24] set_b_bits, [32:29] valid_count,
                                       // [34:33] status, [35] format_seen,
                                       // [51:36] total_bits, [55:52] zero
  output logic             out_tuser,  // item_kind
  output logic             out_tlast,  // final_item

  // Pair-mode register write.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data
);

  logic            pair_mode_r;
  logic            in_valid_r;
  logic [7:0]      in_byte_r;
  logic            in_last_r;
  logic            take;
  logic            room;
  sbpd_pkg::push_t push;
  sbpd_pkg::res_t  out_item;

  // Configuration is always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_mode_r <= 1'b1;
    end else if (cfg_valid) begin
      pair_mode_r <= cfg_data;
    end
  end

  // Input register: advance the held request into decode when the result
  // queue has space for two results, and refill in the same cycle.
  assign take      = in_valid_r && room;
  assign in_tready = !in_valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  // Header walk, payload unpacking and end-of-message status.
  sbpd_decode u_decode (
    .clk            (clk),
    .rst_n          (rst_n),
    .take           (take),
    .data_byte      (in_byte_r),
    .end_of_message (in_last_r),
    .pair_mode      (pair_mode_r),
    .push           (push)
  );

  // Result queue; its head drives the output port directly.
  sbpd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (out_item)
  );

  // Pack the result, first field in the low bits.
  assign out_tdata = {4'd0,
                      out_item.total_bits,
                      out_item.format_seen,
                      out_item.status,
                      out_item.valid_count,
                      out_item.set_b_bits,
                      out_item.set_a_bits,
                      out_item.first_index};
  assign out_tuser = out_item.item_kind;
  assign out_tlast = out_item.final_item;

`ifndef ASSERT_OFF
  a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !room) |=> (in_valid_r && $stable(in_byte_r) && $stable(in_last_r)))
    else $error("held request lost while the queue was full");
`endif

endmodule

`default_nettype wire

// ===== test/signer_bitmap_pair_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// signer_bitmap_pair_decoder_tb
// Self-checking bench for the signer bitmap pair decoder.
// ----------------------------------------------------------------------------
// Feeds serialized signer bitmaps byte by byte, predicts every chunk and
// status result in a scoreboard that tracks header, format and payload count,
// and compares each result field by field in arrival order. A short directed
// set covers the header and length corner cases. Random messages follow, in
// four phases that vary the sender gaps, the receiver stalls and pair mode.
// ----------------------------------------------------------------------------
`default_nettype none

module signer_bitmap_pair_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD      = 8;
  localparam int RESET_CYCLES    = 12;
  localparam int ITEMS_PER_PHASE = 500;
  // Leave some margin after the queue empties.
  localparam int SETTLE_CYCLES   = 6;
  localparam int LIMIT_NS        = 2_000_000 * CLK_PERIOD;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the decoder state and holds the results still owed.
  // --------------------------------------------------------------------------
  class pair_bitmap_scoreboard;
    bit                   pair_mode = 1'b1;
    sbpd_pkg::hdr_state_t hdr_pos;
    logic [7:0]           version;
    logic [15:0]          bit_count;
    logic [15:0]          payload_bytes;
    logic [1:0]           header_error;
    sbpd_pkg::res_t       pending_results[$];
    int                   mismatches;

    function void clear_message();
      hdr_pos       = sbpd_pkg::HS_VERSION;
      version       = '0;
      bit_count     = '0;
      payload_bytes = '0;
      header_error  = sbpd_pkg::ST_OK;
    endfunction

    function int unsigned expected_payload_bytes();
      if (version == sbpd_pkg::VER_PAIR) return (int'(bit_count) + 4) / 5;
      return (int'(bit_count) + 7) / 8;
    endfunction

    function int pending_count();
      return pending_results.size();
    endfunction

    // Predict the results of one accepted request. Return 1 unless the byte
    // is a payload byte that the decoder simply drops.
    function bit note_request(logic [7:0] b, logic last);
      sbpd_pkg::res_t r;
      bit             in_header;
      bit             pair_fmt;
      bit             useful;
      int unsigned    per;
      int unsigned    start;
      int unsigned    cnt;
      int unsigned    rem;
      int unsigned    digit;
      in_header = (hdr_pos != sbpd_pkg::HS_PAYLOAD);
      useful    = in_header;
      if (in_header) begin
        case (hdr_pos)
          sbpd_pkg::HS_VERSION: version = b;
          sbpd_pkg::HS_LEN_LO:  bit_count = {8'd0, b};
          default: begin
            bit_count[15:8] = b;
            // Version check wins over the size check.
            if (version > {7'd0, pair_mode}) header_error = sbpd_pkg::ST_FORMAT;
            else if (bit_count > sbpd_pkg::MAX_SET_BITS) header_error = sbpd_pkg::ST_SIZE;
            else header_error = sbpd_pkg::ST_OK;
          end
        endcase
        hdr_pos = sbpd_pkg::hdr_state_t'(hdr_pos + 1);
        if (last && hdr_pos != sbpd_pkg::HS_PAYLOAD) begin
          // Header cut short.
          r             = '0;
          r.item_kind   = sbpd_pkg::KIND_STATUS;
          r.status      = sbpd_pkg::ST_SIZE;
          r.final_item  = 1'b1;
          pending_results.push_back(r);
          clear_message();
          return 1'b1;
        end
      end else begin
        if (header_error == sbpd_pkg::ST_OK && payload_bytes < expected_payload_bytes()) begin
          pair_fmt = (version == sbpd_pkg::VER_PAIR);
          per      = pair_fmt ? 5 : 8;
          start    = payload_bytes * per;
          cnt      = (bit_count - start < per) ? bit_count - start : per;
          r             = '0;
          r.item_kind   = sbpd_pkg::KIND_CHUNK;
          r.first_index = start[15:0];
          r.valid_count = cnt[3:0];
          r.format_seen = pair_fmt;
          r.total_bits  = bit_count;
          if (pair_fmt) begin
            rem = b;
            for (int j = 0; j < cnt; j++) begin
              digit = rem % 3;
              rem   = rem / 3;
              if (digit == 1) r.set_a_bits[j] = 1'b1;
              else if (digit == 2) r.set_b_bits[j] = 1'b1;
            end
          end else begin
            r.set_a_bits = 8'(b & ((1 << cnt) - 1));
          end
          pending_results.push_back(r);
          useful = 1'b1;
        end
        if (payload_bytes != 16'hFFFF) payload_bytes++;
      end
      if (last) begin
        r             = '0;
        r.item_kind   = sbpd_pkg::KIND_STATUS;
        r.final_item  = 1'b1;
        r.format_seen = (version == sbpd_pkg::VER_PAIR);
        r.total_bits  = bit_count;
        if (header_error != sbpd_pkg::ST_OK) r.status = header_error;
        else if (payload_bytes != expected_payload_bytes()) r.status = sbpd_pkg::ST_FORMAT;
        else r.status = sbpd_pkg::ST_OK;
        pending_results.push_back(r);
        clear_message();
        useful = 1'b1;
      end
      return useful;
    endfunction

    task report(string field, logic [63:0] got, logic [63:0] want);
      if (mismatches < 100)
        $display("%0t mismatch %s: got 0x%0h want 0x%0h", $time, field, got, want);
      mismatches++;
    endtask

    task check_result(logic [55:0] data, logic kind, logic last);
      sbpd_pkg::res_t want;
      if (pending_results.size() == 0) begin
        report("result with nothing pending", {8'd0, data}, '0);
        return;
      end
      want = pending_results.pop_front();
      if (kind !== want.item_kind)           report("item_kind", kind, want.item_kind);
      if (data[15:0] !== want.first_index)   report("first_index", data[15:0], want.first_index);
      if (data[23:16] !== want.set_a_bits)   report("set_a_bits", data[23:16], want.set_a_bits);
      if (data[28:24] !== want.set_b_bits)   report("set_b_bits", data[28:24], want.set_b_bits);
      if (data[32:29] !== want.valid_count)  report("valid_count", data[32:29], want.valid_count);
      if (data[34:33] !== want.status)       report("status", data[34:33], want.status);
      if (data[35] !== want.format_seen)     report("format_seen", data[35], want.format_seen);
      if (data[51:36] !== want.total_bits)   report("total_bits", data[51:36], want.total_bits);
      if (data[55:52] !== 4'd0)              report("tdata padding", data[55:52], 0);
      if (last !== want.final_item)          report("final_item", last, want.final_item);
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Signals and block under test
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;

  // Idle percentages for the sender gaps and receiver stalls of the current phase.
  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  int          phase_items;

  pair_bitmap_scoreboard sb = new;

  signer_bitmap_pair_decoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Stall the result channel at random; drive on the falling edge only.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Check every result taken at a rising edge.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser, out_tlast);
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Offer one byte, after a random gap, and hold it until the request is taken.
  task automatic send_byte(input logic [7:0] b, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    if (sb.note_request(b, last)) phase_items++;
  endtask

  // Version byte and bit count, low byte first; optionally end the message there.
  task automatic send_header(input logic [7:0] ver, input logic [15:0] bits,
                             input logic last);
    send_byte(ver, 1'b0);
    send_byte(bits[7:0], 1'b0);
    send_byte(bits[15:8], last);
  endtask

  task automatic send_message(input logic [7:0] ver, input logic [15:0] bits,
                              input int unsigned payload_len);
    send_header(ver, bits, payload_len == 0);
    for (int unsigned i = 0; i < payload_len; i++)
      send_byte(8'($urandom_range(255)), i == payload_len - 1);
  endtask

  // Mostly well-formed messages with random content; some broken ones.
  task automatic random_message();
    int unsigned pick;
    int unsigned exact;
    int unsigned len;
    int unsigned delta;
    logic [7:0]  ver;
    logic [15:0] bits;
    pick = $urandom_range(99);
    if (pick < 5) begin
      // Header cut after one or two bytes.
      len = $urandom_range(1, 2);
      for (int unsigned i = 0; i < len; i++)
        send_byte(8'($urandom_range(255)), i == len - 1);
      return;
    end
    pick = $urandom_range(99);
    ver  = (pick < 88) ? 8'($urandom_range(1)) : 8'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 88)      bits = 16'($urandom_range(60));
    else if (pick < 92) bits = 16'($urandom_range(61, 300));
    else if (pick < 95) bits = sbpd_pkg::MAX_SET_BITS - 16'd1 + 16'($urandom_range(2));
    else                bits = 16'($urandom_range(65535));
    exact = (ver == sbpd_pkg::VER_PAIR) ? (int'(bits) + 4) / 5 : (int'(bits) + 7) / 8;
    pick  = $urandom_range(99);
    if (exact > 420) begin
      // Oversized count: the header already fails, keep the payload short.
      len = $urandom_range(6);
    end else if (pick < 75) begin
      len = exact;
    end else if (pick < 90) begin
      delta = $urandom_range(1, 3);
      if ($urandom_range(1)) len = exact + delta;
      else len = (exact > delta) ? exact - delta : 0;
    end else begin
      len = $urandom_range(8);
    end
    send_message(ver, bits, len);
  endtask

  // Drop valid, wait for every owed result, then let the pipeline settle.
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;
    while (sb.pending_count() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_pair_mode(input bit mode);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk); while (!cfg_ready);
    sb.pair_mode = mode;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned gap_pct, input int unsigned stall_pct,
                           input bit mode);
    write_pair_mode(mode);
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    phase_items    = 0;
    while (phase_items < ITEMS_PER_PHASE) random_message();
    drain();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb.clear_message();
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    write_pair_mode(1'b1);

    // Header ending after one byte, then after two.
    send_byte(8'h5A, 1'b1);
    send_byte(sbpd_pkg::VER_PAIR, 1'b0);
    send_byte(8'hFF, 1'b1);
    // Empty bitmap: message ends on the last header byte.
    send_header(sbpd_pkg::VER_BINARY, 16'd0, 1'b1);
    // Pair format, seven positions: all-B digits, then a byte above 242.
    send_header(sbpd_pkg::VER_PAIR, 16'd7, 1'b0);
    send_byte(8'd242, 1'b0);
    send_byte(8'hFF, 1'b1);
    // Binary, nine positions, one byte too many: length mismatch.
    send_header(sbpd_pkg::VER_BINARY, 16'd9, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b1);
    // Unknown version suppresses chunks.
    send_header(8'h02, 16'd8, 1'b0);
    send_byte(8'h3C, 1'b1);
    // Bit count one above the limit.
    send_header(sbpd_pkg::VER_BINARY, sbpd_pkg::MAX_SET_BITS + 16'd1, 1'b1);
    drain();

    run_phase(0, 0, 1'b1);
    run_phase(62, 0, 1'b0);
    run_phase(0, 62, 1'b1);
    run_phase(15, 15, 1'b0);

    if (sb.mismatches == 0 && sb.pending_count() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #(LIMIT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
hdl/sbpd_pkg.sv
hdl/sbpd_decode.sv
hdl/sbpd_out_fifo.sv
hdl/signer_bitmap_pair_decoder.sv
test/signer_bitmap_pair_decoder_tb.sv
